/* sv/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and modular helpers for the strong subgraph counter.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned ValW = 30;
  localparam logic [ValW-1:0] Modulus = 30'd1000000007;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PFILL,
    ST_SINIT,
    ST_A_RD,
    ST_A_MUL,
    ST_A_WAIT,
    ST_IND_RD,
    ST_IND_WR,
    ST_F_INIT,
    ST_B_RD,
    ST_B_CALC,
    ST_B_MUL,
    ST_B_WAIT,
    ST_S_FIN
  } st_e;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_RUN  = 1'b1
  } req_e;

  function automatic logic [ValW-1:0] sub_mod(input logic [ValW-1:0] x,
                                               input logic [ValW-1:0] y);
    logic [ValW:0] t;
    t = {1'b0, x} + {1'b0, Modulus} - {1'b0, y};
    return (x >= y) ? (x - y) : t[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] add_mod(input logic [ValW-1:0] x,
                                               input logic [ValW-1:0] y);
    logic [ValW:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, Modulus}) begin
      t = t - {1'b0, Modulus};
    end
    return t[ValW-1:0];
  endfunction

endpackage

/* sv/ssc_ram.sv */
// ----------------------------------------------------------------------------
// ssc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ssc_mulmod.sv */
// ----------------------------------------------------------------------------
// ssc_mulmod
// Iterative modular multiplier, two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module ssc_mulmod
  import ssc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] a_i,
  input  logic [ValW-1:0] b_i,
  output logic            done_o,
  output logic [ValW-1:0] prod_o
);

  localparam int unsigned Steps = ValW / 2;
  localparam int unsigned CntW  = $clog2(Steps);
  localparam logic [CntW-1:0] CntLast = CntW'(Steps - 1);

  logic [ValW-1:0] a_q, b_q, acc_q, acc_d;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;

  // acc*2 + bit*a, both < p, so at most two moduli to take off
  function automatic logic [ValW-1:0] dbl_add(input logic [ValW-1:0] acc,
                                               input logic bit_i,
                                               input logic [ValW-1:0] a);
    logic [ValW+1:0] t;
    logic [ValW+1:0] p2;
    p2 = {1'b0, Modulus, 1'b0};
    t  = {1'b0, acc, 1'b0} + (bit_i ? {2'b00, a} : '0);
    if (t >= p2) begin
      t = t - p2;
    end else if (t >= {2'b00, Modulus}) begin
      t = t - {2'b00, Modulus};
    end
    return t[ValW-1:0];
  endfunction

  assign acc_d = dbl_add(dbl_add(acc_q, b_q[ValW-1], a_q), b_q[ValW-2], a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      b_q   <= {b_q[ValW-3:0], 2'b00};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  a_done_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (prod_o < Modulus))
    else $error("mulmod product not reduced");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(run_q))
    else $error("mulmod done without a running product");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q)
    else $error("mulmod started while busy");

endmodule

/* sv/strong_subgraph_counter.sv */
// ----------------------------------------------------------------------------
// strong_subgraph_counter
// Counts edge subsets whose spanning subgraph is strongly connected, mod p,
// with a subset DP and inclusion-exclusion over submasks.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                        handshake
//  request   in         req_type_i, src_vertex_i, dst_vertex_i       start & !busy
//  result    out        subgraph_count_o                             result_valid_o
//  config    in         vertex_count_i                               cfg_we_i
//
//  Edge transactions leave busy low.
//  A run transaction first fills the power-of-two table (MaxVertices^2 entries),
//  then walks every submask pair of each subset, first in the signed pass and
//  then in the strong pass; each pair uses the 15-step shared modular multiplier.
//  Result strobes for one cycle at the end; the receiver cannot stall.
//  Reset clears control state and the adjacency; working RAMs need no clear.
// ----------------------------------------------------------------------------
module strong_subgraph_counter
  import ssc_pkg::*;
#(
  parameter int unsigned MaxVertices = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type_i,
  input  logic [$clog2(MaxVertices)-1:0]     src_vertex_i,
  input  logic [$clog2(MaxVertices)-1:0]     dst_vertex_i,
  input  logic                               cfg_we_i,
  input  logic [$clog2(MaxVertices+1)-1:0]   vertex_count_i,
  output logic                               result_valid_o,
  output logic [ValW-1:0]                    subgraph_count_o
);

  localparam int unsigned N        = MaxVertices;
  localparam int unsigned VtxW     = $clog2(N);
  localparam int unsigned CntW     = $clog2(N + 1);
  localparam int unsigned SubDepth = 2 ** N;
  localparam int unsigned PowDepth = N * N;
  localparam int unsigned PW       = $clog2(PowDepth);
  localparam logic [PW-1:0]   PowLast  = PW'(PowDepth - 1);
  localparam logic [PW:0]     PowLimit = (PW + 1)'(PowDepth);
  localparam logic [CntW-1:0] CntMax   = CntW'(N);
  localparam logic [CntW-1:0] CfgReset = CntW'((N < 15) ? N : 15);

  function automatic logic [VtxW-1:0] low_idx(input logic [N-1:0] x);
    logic [VtxW-1:0] idx;
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (x[i]) idx = VtxW'(i);
    end
    return idx;
  endfunction

  function automatic logic [CntW-1:0] popcnt(input logic [N-1:0] x);
    logic [CntW-1:0] c;
    c = '0;
    for (int i = 0; i < N; i++) begin
      c = c + CntW'(x[i]);
    end
    return c;
  endfunction

  st_e state_q, state_d;

  logic [CntW-1:0] cfg_q, n_eff;
  logic [N-1:0]    out_adj_q [N];
  logic [N-1:0]    in_adj_q  [N];
  logic [N-1:0]    s_q, t_q, full_mask;
  logic [ValW-1:0] g_q, f_q, pval_q;
  logic [PW-1:0]   pidx_q;
  logic            result_valid_q;
  logic [ValW-1:0] count_q;

  logic [N-1:0]    low, rest, comp, bit_mk, t_dec_rest, t_dec_s;
  logic [VtxW-1:0] lk, mk, vsel;
  logic [N-1:0]    out_row, in_row;
  logic [PW-1:0]   ind_new, cross_new;
  logic [PW:0]     e_sum;
  logic [PW-1:0]   e_idx;
  logic            accept, edge_ok;

  // RAM ports
  logic            pow_we, ind_we, crs_we, sgn_we, str_we;
  logic [PW-1:0]   pow_waddr, pow_raddr, ind_waddr, ind_raddr;
  logic [N-1:0]    sub_waddr, ind_wsub, ind_rsub, crs_raddr, sgn_raddr, str_raddr;
  logic [ValW-1:0] pow_rdata, sgn_rdata, str_rdata, sgn_wdata;
  logic [PW-1:0]   ind_rdata, crs_rdata, ind_wdata;

  logic            mul_start, mul_done;
  logic [ValW-1:0] mul_a, mul_prod;

  assign n_eff = (cfg_q == '0) ? CntW'(1) : ((cfg_q > CntMax) ? CntMax : cfg_q);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      full_mask[i] = (CntW'(i) < n_eff);
    end
  end

  assign accept  = start && !busy;
  assign edge_ok = (CntW'(src_vertex_i) < n_eff) && (CntW'(dst_vertex_i) < n_eff) &&
                   (src_vertex_i != dst_vertex_i);

  assign low        = s_q & (~s_q + 1'b1);
  assign rest       = s_q ^ low;
  assign lk         = low_idx(s_q);
  assign comp       = s_q ^ t_q;
  assign mk         = low_idx(comp);
  assign bit_mk     = N'(1) << mk;
  assign vsel       = (state_q == ST_IND_WR) ? lk : mk;
  assign out_row    = out_adj_q[vsel];
  assign in_row     = in_adj_q[vsel];
  assign t_dec_rest = (t_q - 1'b1) & rest;
  assign t_dec_s    = (t_q - 1'b1) & s_q;

  assign ind_new = ind_rdata + PW'(popcnt(in_row & rest)) + PW'(popcnt(out_row & rest));

  // edges from the complement into t, updated by moving vertex mk out of t
  always_comb begin
    logic [PW:0] c;
    c = {1'b0, crs_rdata} + (PW + 1)'(popcnt(out_row & t_q))
        - (PW + 1)'(popcnt(in_row & comp));
    cross_new = (t_q == s_q) ? '0 : c[PW-1:0];
  end

  assign e_sum = {1'b0, ind_rdata} + {1'b0, cross_new};
  assign e_idx = (e_sum >= PowLimit) ? '0 : e_sum[PW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && req_type_i == REQ_RUN) state_d = ST_PFILL;
      ST_PFILL:  if (pidx_q == PowLast) state_d = ST_SINIT;
      ST_SINIT:  state_d = (rest == '0) ? ST_IND_RD : ST_A_RD;
      ST_A_RD:   state_d = ST_A_MUL;
      ST_A_MUL:  state_d = ST_A_WAIT;
      ST_A_WAIT: if (mul_done) state_d = (t_dec_rest == '0) ? ST_IND_RD : ST_A_RD;
      ST_IND_RD: state_d = ST_IND_WR;
      ST_IND_WR: state_d = ST_F_INIT;
      ST_F_INIT: state_d = ST_B_RD;
      ST_B_RD:   state_d = ST_B_CALC;
      ST_B_CALC: state_d = ST_B_MUL;
      ST_B_MUL:  state_d = ST_B_WAIT;
      ST_B_WAIT: if (mul_done) state_d = (t_dec_s == '0) ? ST_S_FIN : ST_B_RD;
      ST_S_FIN:  state_d = (s_q == full_mask) ? ST_IDLE : ST_SINIT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // RAM and multiplier controls
  always_comb begin
    pow_we    = 1'b0;
    pow_waddr = pidx_q;
    pow_raddr = ind_new;
    ind_we    = 1'b0;
    ind_wsub  = s_q;
    ind_wdata = ind_new;
    ind_rsub  = s_q ^ t_q;
    crs_we    = 1'b0;
    crs_raddr = t_q | bit_mk;
    sgn_we    = 1'b0;
    sgn_wdata = g_q;
    sgn_raddr = t_q;
    str_we    = 1'b0;
    str_raddr = s_q ^ t_q;
    mul_start = 1'b0;
    mul_a     = pow_rdata;
    case (state_q)
      ST_PFILL: begin
        pow_we    = 1'b1;
        ind_we    = (pidx_q == '0);
        ind_wsub  = '0;
        ind_wdata = '0;
      end
      ST_A_MUL: begin
        mul_start = 1'b1;
        mul_a     = str_rdata;
      end
      ST_IND_RD: begin
        ind_rsub = rest;
        sgn_we   = 1'b1;
      end
      ST_IND_WR: ind_we = 1'b1;
      ST_B_CALC: begin
        crs_we    = 1'b1;
        pow_raddr = e_idx;
      end
      ST_B_MUL:  mul_start = 1'b1;
      ST_S_FIN: begin
        str_we    = 1'b1;
        sgn_we    = 1'b1;
        sgn_wdata = add_mod(g_q, f_q);
      end
      default: ;
    endcase
  end

  assign ind_waddr = PW'(0);
  assign ind_raddr = PW'(0);
  assign sub_waddr = (state_q == ST_B_CALC) ? t_q : s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cfg_q          <= CfgReset;
      result_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        out_adj_q[i] <= '0;
        in_adj_q[i]  <= '0;
      end
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;
      if (cfg_we_i) begin
        cfg_q <= vertex_count_i;
      end
      if (state_q == ST_IDLE && accept && req_type_i == REQ_EDGE && edge_ok) begin
        out_adj_q[src_vertex_i][dst_vertex_i] <= 1'b1;
        in_adj_q[dst_vertex_i][src_vertex_i]  <= 1'b1;
      end
      if (state_q == ST_S_FIN && s_q == full_mask) begin
        result_valid_q <= 1'b1;
        for (int i = 0; i < N; i++) begin
          out_adj_q[i] <= '0;
          in_adj_q[i]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        pidx_q <= '0;
        pval_q <= ValW'(1);
      end
      ST_PFILL: begin
        pidx_q <= pidx_q + 1'b1;
        pval_q <= add_mod(pval_q, pval_q);
        s_q    <= N'(1);
      end
      ST_SINIT: begin
        t_q <= rest;
        g_q <= '0;
      end
      ST_A_WAIT: if (mul_done) begin
        g_q <= sub_mod(g_q, mul_prod);
        t_q <= t_dec_rest;
      end
      ST_F_INIT: begin
        f_q <= pow_rdata;
        t_q <= s_q;
      end
      ST_B_WAIT: if (mul_done) begin
        f_q <= sub_mod(f_q, mul_prod);
        t_q <= t_dec_s;
      end
      ST_S_FIN: begin
        s_q     <= s_q + 1'b1;
        count_q <= f_q;
      end
      default: ;
    endcase
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = result_valid_q;
  assign subgraph_count_o = count_q;

  ssc_ram #(.Width(ValW), .Depth(PowDepth)) u_pow_ram (
    .clk_i, .we_i(pow_we), .waddr_i(pow_waddr), .wdata_i(pval_q),
    .raddr_i(pow_raddr), .rdata_o(pow_rdata)
  );

  ssc_ram #(.Width(PW), .Depth(SubDepth)) u_ind_ram (
    .clk_i, .we_i(ind_we), .waddr_i(ind_wsub | N'(ind_waddr)), .wdata_i(ind_wdata),
    .raddr_i(ind_rsub | N'(ind_raddr)), .rdata_o(ind_rdata)
  );

  ssc_ram #(.Width(PW), .Depth(SubDepth)) u_crs_ram (
    .clk_i, .we_i(crs_we), .waddr_i(sub_waddr), .wdata_i(cross_new),
    .raddr_i(crs_raddr), .rdata_o(crs_rdata)
  );

  ssc_ram #(.Width(ValW), .Depth(SubDepth)) u_sgn_ram (
    .clk_i, .we_i(sgn_we), .waddr_i(sub_waddr), .wdata_i(sgn_wdata),
    .raddr_i(sgn_raddr), .rdata_o(sgn_rdata)
  );

  ssc_ram #(.Width(ValW), .Depth(SubDepth)) u_str_ram (
    .clk_i, .we_i(str_we), .waddr_i(sub_waddr), .wdata_i(f_q),
    .raddr_i(str_raddr), .rdata_o(str_rdata)
  );

  ssc_mulmod u_mulmod (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(sgn_rdata),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (subgraph_count_o < Modulus))
    else $error("result not reduced");

  a_run_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_RUN) |=> busy)
    else $error("run transaction did not start");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

endmodule
